[hw/rtl/wildcard_match_dp_stream_top_defines.svh]
// Assertion macros for the wildcard matcher RTL.
// Included by files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef WILDCARD_MATCH_DP_STREAM_TOP_DEFINES_SVH
`define WILDCARD_MATCH_DP_STREAM_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Plain property check, disabled during reset.
`define WMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent this cycle, consequent in the next cycle.
`define WMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WMD_ASSERT(lbl, prop, msg)
`define WMD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/wmd_pkg.sv]
// Shared types and constants for the wildcard matcher.
// No dependencies.
package wmd_pkg;

  localparam logic [7:0] STAR_CHAR  = 8'h2A;
  localparam logic [7:0] ANY_CHAR   = 8'h3F;

  localparam int unsigned CFG_ADDR_W = 6;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned REG_BYTES  = 8;   // pattern bytes per register
  localparam int unsigned PAT_REGS   = 4;   // pattern registers
  localparam int unsigned PAT_STORE  = REG_BYTES * PAT_REGS;

  typedef enum logic [2:0] {
    REG_PAT0 = 3'd0,
    REG_PAT1 = 3'd1,
    REG_PAT2 = 3'd2,
    REG_PAT3 = 3'd3,
    REG_LEN  = 3'd4
  } reg_idx_t;

  // Signals passed from one cell to its right neighbor.
  typedef struct packed {
    logic old_bit;    // reach bit before this item
    logic new_bit;    // reach bit after this item
    logic start_bit;  // restart value (leading stars)
  } link_t;

endpackage

[hw/rtl/wildcard_match_dp_stream_top.sv]
// Streaming glob matcher: each input item carries one text byte, each result item says
// whether the text since its start, through that byte, matches the whole configured
// pattern ('*' = any run, '?' = any one byte). One item per clock: the block takes a new
// byte every cycle while out_stall is low, and the result appears in an output register
// in the cycle after acceptance. Cycle time is set by the chain of cells, one per
// pattern position, where a run of stars ripples the new reach bit left to right in the
// same cycle. An item flagged last, or any write to a pattern or length register, makes
// the next text start fresh. Registers sit at byte addresses 8*i on the 64-bit APB-style
// port; pready is tied high. No clearing pass after reset.
`include "wildcard_match_dp_stream_top_defines.svh"

module wildcard_match_dp_stream_top
  import wmd_pkg::*;
#(
  parameter int unsigned PATTERN_CHARS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_text_char,
  input  logic                  in_last,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_prefix_match,
  output logic                  out_end_of_text,
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int unsigned LEN_W = $clog2(PATTERN_CHARS + 1);

  logic [PATTERN_CHARS-1:0][7:0] pat;
  logic [LEN_W-1:0]              pat_len;
  logic                          cfg_wr_hit;
  logic                          accept;
  logic                          restart_r;
  logic                          restart_nxt;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic                          out_prefix_match_r;
  logic                          out_end_of_text_r;
  logic                          match_bit;
  link_t                         link [PATTERN_CHARS+1];

  assign cfg_pready = 1'b1;

  wmd_cfg #(
    .PATTERN_CHARS(PATTERN_CHARS)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .pat        (pat),
    .pat_len    (pat_len),
    .wr_hit     (cfg_wr_hit)
  );

  // Output register parts the two sides: take a byte whenever the result slot is free
  // or being drained this cycle.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Position zero has no cell: empty prefix matches only at the start of a text,
  // and is never reachable after a byte has been consumed.
  assign link[0] = '{old_bit: restart_r, new_bit: 1'b0, start_bit: 1'b1};

  for (genvar p = 0; p < PATTERN_CHARS; p++) begin : g_cell
    wmd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .step      (accept),
      .restart   (restart_r),
      .active    (LEN_W'(p + 1) <= pat_len),
      .pat_char  (pat[p]),
      .text_char (in_text_char),
      .left_link (link[p]),
      .right_link(link[p+1])
    );
  end

  // whole pattern matched: new reach bit at the last position in use
  assign match_bit = link[pat_len].new_bit;

  // restart: after reset, after a last byte, after any config write
  always_comb begin
    restart_nxt = restart_r;
    if (cfg_wr_hit) begin
      restart_nxt = 1'b1;
    end else if (accept) begin
      restart_nxt = in_last;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      restart_r   <= restart_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_prefix_match_r <= match_bit;
      out_end_of_text_r  <= in_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_prefix_match = out_prefix_match_r;
  assign out_end_of_text  = out_end_of_text_r;

  `WMD_ASSERT_NEXT(a_accept_result, accept, out_valid_r && (out_end_of_text_r == $past(in_last)), "accepted item did not produce a result")
  `WMD_ASSERT_NEXT(a_empty_no_match, accept && (pat_len == '0), !out_prefix_match_r, "empty pattern reported a match")
  `WMD_ASSERT_NEXT(a_cfg_restart, cfg_wr_hit, restart_r, "config write did not restart the text")
  `WMD_ASSERT(a_stall_held, !in_stall || out_valid_r, "input stalled with no pending result")

endmodule

[hw/rtl/wmd_cell.sv]
// One pattern position of the matcher chain: holds its reach bit.
// Depends on wmd_pkg.
module wmd_cell
  import wmd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       restart,
  input  logic       active,
  input  logic [7:0] pat_char,
  input  logic [7:0] text_char,
  input  link_t      left_link,
  output link_t      right_link
);

  logic reach_r;
  logic reach_nxt;
  logic is_star;
  logic char_eq;
  logic start_bit;
  logic old_bit;

  assign is_star   = (pat_char == STAR_CHAR);
  assign char_eq   = (pat_char == ANY_CHAR) || (pat_char == text_char);
  assign start_bit = left_link.start_bit & active & is_star;
  assign old_bit   = restart ? start_bit : reach_r;

  // star: keep own bit or take new bit from the left; else diagonal AND compare
  assign reach_nxt = active & (is_star ? (old_bit | left_link.new_bit)
                                       : (char_eq & left_link.old_bit));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reach_r <= 1'b0;
    end else if (step) begin
      reach_r <= reach_nxt;
    end
  end

  assign right_link = '{old_bit: old_bit, new_bit: reach_nxt, start_bit: start_bit};

endmodule

[hw/rtl/wmd_cfg.sv]
// Configuration registers of the matcher: pattern bytes and pattern length.
// Depends on wmd_pkg.
module wmd_cfg
  import wmd_pkg::*;
#(
  parameter int unsigned PATTERN_CHARS = 32,
  localparam int unsigned LEN_W = $clog2(PATTERN_CHARS + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]               cfg_paddr,
  input  logic [CFG_DATA_W-1:0]               cfg_pwdata,
  output logic [CFG_DATA_W-1:0]               cfg_prdata,
  output logic [PATTERN_CHARS-1:0][7:0]       pat,
  output logic [LEN_W-1:0]                    pat_len,
  output logic                                wr_hit
);

  logic [PATTERN_CHARS-1:0][7:0] pat_r;
  logic [LEN_W-1:0]              len_r;
  logic [LEN_W-1:0]              len_nxt;
  logic [2:0]                    idx;
  logic                          wr_en;
  logic [PATTERN_CHARS-1:0]      byte_we;
  logic [PAT_REGS-1:0][CFG_DATA_W-1:0] rd_word;

  assign idx    = cfg_paddr[CFG_ADDR_W-1:3];
  assign wr_en  = cfg_psel && cfg_penable && cfg_pwrite;
  assign wr_hit = wr_en && (idx inside {[REG_PAT0:REG_LEN]});

  // saturate length at the number of cells
  assign len_nxt = (cfg_pwdata[5:0] > 6'(PATTERN_CHARS)) ? LEN_W'(PATTERN_CHARS)
                                                         : LEN_W'(cfg_pwdata[5:0]);

  always_comb begin
    for (int p = 0; p < PATTERN_CHARS; p++) begin
      byte_we[p] = wr_en && (p < PAT_STORE) && (idx == 3'(p / REG_BYTES));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0;
      len_r <= '0;
    end else begin
      for (int p = 0; p < PATTERN_CHARS; p++) begin
        if (byte_we[p]) begin
          pat_r[p] <= cfg_pwdata[(p % REG_BYTES)*8 +: 8];
        end
      end
      if (wr_en && idx == REG_LEN) begin
        len_r <= len_nxt;
      end
    end
  end

  // read-back words, bytes without storage read as zero
  for (genvar r = 0; r < PAT_REGS; r++) begin : g_rd
    for (genvar b = 0; b < REG_BYTES; b++) begin : g_byte
      if (r * REG_BYTES + b < PATTERN_CHARS) begin : g_have
        assign rd_word[r][b*8 +: 8] = pat_r[r * REG_BYTES + b];
      end else begin : g_none
        assign rd_word[r][b*8 +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    case (idx)
      REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: cfg_prdata = rd_word[idx[1:0]];
      REG_LEN: cfg_prdata = CFG_DATA_W'(len_r);
      default: cfg_prdata = '0;
    endcase
  end

  assign pat     = pat_r;
  assign pat_len = len_r;

endmodule
